// ===== rtl/bcs_pkg.sv =====
// Shared types, register codes and constants of the barometric compensation sequencer.
package bcs_pkg;

  localparam int EXTRA_FRACTION_BITS = 5;
  localparam int TEMP_SHIFT = 23 - EXTRA_FRACTION_BITS;
  localparam int PRES_SHIFT = 15 - EXTRA_FRACTION_BITS;
  localparam int TEMP_BASE = 2000 * (2 ** EXTRA_FRACTION_BITS);
  localparam int OFF_COEFF_SHIFT = 7;
  localparam int SENS_COEFF_SHIFT = 8;
  localparam int OFF_BASE_SHIFT = 16;
  localparam int SENS_BASE_SHIFT = 15;
  localparam int RAW_SENS_SHIFT = 21;
  localparam int SENS_LO_W = 17;

  localparam int TICK_W = 32;
  localparam int RAW_W = 24;
  localparam int PRES_W = 27;
  localparam int TEMP_W = 24;
  localparam int COEFF_W = 16;
  localparam int PHASE_W = 4;
  localparam int POLL_W = 8;
  localparam int DT_W = 25;
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int OFF_W = 36;
  localparam int SENS_W = SENS_LO_W + MUL_B_W;
  localparam int ACC_W = 60;
  localparam int CFG_INDEX_W = 3;

  localparam logic [1:0] NS_NONE = 2'd0;
  localparam logic [1:0] NS_PRESSURE = 2'd1;
  localparam logic [1:0] NS_TEMPERATURE = 2'd2;

  localparam logic KIND_TEMPERATURE = 1'b0;
  localparam logic KIND_PRESSURE = 1'b1;

  localparam logic [PHASE_W-1:0] READS_RESET = 4'd5;
  localparam logic [POLL_W-1:0] POLL_RESET = 8'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PRESSURE_SENSITIVITY = 3'd0,
    REG_PRESSURE_OFFSET      = 3'd1,
    REG_SENS_TEMP_COEFF      = 3'd2,
    REG_OFFSET_TEMP_COEFF    = 3'd3,
    REG_REFERENCE_TEMP       = 3'd4,
    REG_TEMP_SENSITIVITY     = 3'd5,
    REG_READS_PER_CYCLE      = 3'd6,
    REG_MIN_POLL_TICKS       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [COEFF_W-1:0] pressure_sensitivity;
    logic [COEFF_W-1:0] pressure_offset;
    logic [COEFF_W-1:0] sens_temp_coeff;
    logic [COEFF_W-1:0] offset_temp_coeff;
    logic [COEFF_W-1:0] reference_temp;
    logic [COEFF_W-1:0] temp_sensitivity;
    logic [PHASE_W-1:0] reads_per_cycle;
    logic [POLL_W-1:0]  min_poll_ticks;
  } cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_now;
    logic [RAW_W-1:0]  raw_value;
  } in_t;

  typedef struct packed {
    logic signed [PRES_W-1:0] pressure_fixed;
    logic signed [TEMP_W-1:0] temperature_fixed;
    logic                     consumed;
    logic                     consumed_kind;
    logic [1:0]               next_start;
  } out_t;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

// ===== rtl/bcs_cfg_regs.sv =====
// Calibration and sequencing register file of the barometric compensation sequencer.
module bcs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [bcs_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [bcs_pkg::COEFF_W-1:0]     wr_data,
  output bcs_pkg::cfg_t                   cfg
);
  import bcs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressure_sensitivity <= '0;
      cfg.pressure_offset <= '0;
      cfg.sens_temp_coeff <= '0;
      cfg.offset_temp_coeff <= '0;
      cfg.reference_temp <= '0;
      cfg.temp_sensitivity <= '0;
      cfg.reads_per_cycle <= READS_RESET;
      cfg.min_poll_ticks <= POLL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_PRESSURE_SENSITIVITY: cfg.pressure_sensitivity <= wr_data;
        REG_PRESSURE_OFFSET:      cfg.pressure_offset <= wr_data;
        REG_SENS_TEMP_COEFF:      cfg.sens_temp_coeff <= wr_data;
        REG_OFFSET_TEMP_COEFF:    cfg.offset_temp_coeff <= wr_data;
        REG_REFERENCE_TEMP:       cfg.reference_temp <= wr_data;
        REG_TEMP_SENSITIVITY:     cfg.temp_sensitivity <= wr_data;
        REG_READS_PER_CYCLE:      cfg.reads_per_cycle <= wr_data[PHASE_W-1:0];
        REG_MIN_POLL_TICKS:       cfg.min_poll_ticks <= wr_data[POLL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/bcs_mul.sv =====
// Shared signed multiplier with registered product.
module bcs_mul (
  input  logic                                clk,
  input  bcs_pkg::mul_op_t                    op,
  output logic signed [bcs_pkg::PROD_W-1:0]   prod
);
  import bcs_pkg::*;

  always_ff @(posedge clk) begin
    if (op.en) begin
      prod <= op.a * op.b;
    end
  end

endmodule

// ===== rtl/baro_compensation_sequencer_unit.sv =====
// Top level: poll sequencer and compensation datapath around one shared multiplier.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | in_data   (tick_now, raw_value)
//  out     | output    | out_valid/out_stall| out_data  (pressure, temperature,
//          |           |                    |            consumed, kind, next)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  A rate-limited poll goes straight to the done state; a read steps through the states
//  of the sequencer, through the one 25x18 multiplier and the 60-bit accumulator.
//  in_stall is high while an item is worked and while its result waits for the output
//  register; once there, a result waits and the next item is accepted meanwhile.
//  rst is synchronous: control, held and config registers reset; no result is pending.
//  cfg_ready is always high; write only while the block is idle.
module baro_compensation_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bcs_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bcs_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bcs_pkg::COEFF_W-1:0]     cfg_data
);
  import bcs_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_T_MUL  = 11'b000_0000_0010,
    ST_T_FIN  = 11'b000_0000_0100,
    ST_P_OFF  = 11'b000_0000_1000,
    ST_P_SENS = 11'b000_0001_0000,
    ST_P_SPLIT = 11'b000_0010_0000,
    ST_P_LO   = 11'b000_0100_0000,
    ST_P_HI   = 11'b000_1000_0000,
    ST_P_ACC  = 11'b001_0000_0000,
    ST_P_FIN  = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  cfg_t cfg;
  mul_op_t mul_op;
  logic signed [PROD_W-1:0] prod;

  logic [PHASE_W-1:0]     read_phase;
  logic [TICK_W-1:0]      last_poll_tick;
  logic signed [DT_W-1:0] held_delta_temp;
  logic signed [PRES_W-1:0] held_pressure;
  logic signed [TEMP_W-1:0] held_temperature;

  logic [RAW_W-1:0]        raw;
  logic signed [OFF_W-1:0] off;
  logic signed [SENS_W-1:0] sens;
  logic signed [ACC_W-1:0] acc;
  out_t res;

  logic in_accept;
  logic limited;
  logic [TICK_W-1:0] tick_diff;
  logic signed [DT_W-1:0] dt_new;
  logic signed [PROD_W-1:0] t_sum;
  logic signed [TEMP_W-1:0] t_val;
  logic signed [PROD_W-1:0] p_diff;
  logic signed [PROD_W-1:0] p_shift;
  logic signed [PRES_W-1:0] p_val;
  logic [PHASE_W-1:0] phase_inc;
  logic phase_wrap;
  logic out_free;

  bcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bcs_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign tick_diff = in_data.tick_now - last_poll_tick;
  assign limited = tick_diff < {{(TICK_W-POLL_W){1'b0}}, cfg.min_poll_ticks};
  assign dt_new = (in_data.raw_value == '0) ? '0 :
                  $signed({1'b0, in_data.raw_value}) -
                  $signed({1'b0, cfg.reference_temp, 8'b0});

  always_comb begin
    t_sum = (prod >>> TEMP_SHIFT) + PROD_W'(TEMP_BASE);
    if (held_delta_temp == '0) begin
      t_val = '0;
    end else if (t_sum < -(PROD_W'(64'sd1) <<< (TEMP_W-1))) begin
      t_val = {1'b1, {(TEMP_W-1){1'b0}}};
    end else if (t_sum > ((PROD_W'(64'sd1) <<< (TEMP_W-1)) - PROD_W'(64'sd1))) begin
      t_val = {1'b0, {(TEMP_W-1){1'b1}}};
    end else begin
      t_val = t_sum[TEMP_W-1:0];
    end
  end

  always_comb begin
    p_diff = PROD_W'(acc >>> RAW_SENS_SHIFT) - PROD_W'(off);
    p_shift = p_diff >>> PRES_SHIFT;
    if (raw == '0 || held_delta_temp == '0) begin
      p_val = '0;
    end else if (p_shift < -(PROD_W'(64'sd1) <<< (PRES_W-1))) begin
      p_val = {1'b1, {(PRES_W-1){1'b0}}};
    end else if (p_shift > ((PROD_W'(64'sd1) <<< (PRES_W-1)) - PROD_W'(64'sd1))) begin
      p_val = {1'b0, {(PRES_W-1){1'b1}}};
    end else begin
      p_val = p_shift[PRES_W-1:0];
    end
  end

  assign phase_inc = read_phase + PHASE_W'(1);
  assign phase_wrap = (phase_inc >= cfg.reads_per_cycle) || (phase_inc == '0);

  always_comb begin
    mul_op = '0;
    case (state)
      ST_T_MUL: begin
        mul_op.en = 1'b1;
        mul_op.a = held_delta_temp;
        mul_op.b = $signed({2'b0, cfg.temp_sensitivity});
      end
      ST_P_OFF: begin
        mul_op.en = 1'b1;
        mul_op.a = held_delta_temp;
        mul_op.b = $signed({2'b0, cfg.offset_temp_coeff});
      end
      ST_P_SENS: begin
        mul_op.en = 1'b1;
        mul_op.a = held_delta_temp;
        mul_op.b = $signed({2'b0, cfg.sens_temp_coeff});
      end
      ST_P_LO: begin
        mul_op.en = 1'b1;
        mul_op.a = $signed({1'b0, raw});
        mul_op.b = $signed({1'b0, sens[SENS_LO_W-1:0]});
      end
      ST_P_HI: begin
        mul_op.en = 1'b1;
        mul_op.a = $signed({1'b0, raw});
        mul_op.b = sens[SENS_W-1:SENS_LO_W];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (limited) begin
            state_next = ST_DONE;
          end else if (read_phase == '0) begin
            state_next = ST_T_MUL;
          end else begin
            state_next = ST_P_OFF;
          end
        end
      end
      ST_T_MUL:   state_next = ST_T_FIN;
      ST_T_FIN:   state_next = ST_DONE;
      ST_P_OFF:   state_next = ST_P_SENS;
      ST_P_SENS:  state_next = ST_P_SPLIT;
      ST_P_SPLIT: state_next = ST_P_LO;
      ST_P_LO:    state_next = ST_P_HI;
      ST_P_HI:    state_next = ST_P_ACC;
      ST_P_ACC:   state_next = ST_P_FIN;
      ST_P_FIN:   state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      read_phase <= '0;
      last_poll_tick <= '0;
      held_delta_temp <= '0;
      held_pressure <= '0;
      held_temperature <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_IDLE && in_accept && !limited) begin
        last_poll_tick <= in_data.tick_now;
        if (read_phase == '0) begin
          read_phase <= PHASE_W'(1);
          held_delta_temp <= dt_new;
        end
      end
      if (state == ST_T_FIN) begin
        held_temperature <= t_val;
      end
      if (state == ST_P_FIN) begin
        held_pressure <= p_val;
        read_phase <= phase_wrap ? '0 : phase_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        raw <= in_data.raw_value;
        res.pressure_fixed <= held_pressure;
        res.temperature_fixed <= held_temperature;
        res.consumed <= 1'b0;
        res.consumed_kind <= KIND_TEMPERATURE;
        res.next_start <= NS_NONE;
      end
      ST_T_FIN: begin
        res.pressure_fixed <= held_pressure;
        res.temperature_fixed <= t_val;
        res.consumed <= 1'b1;
        res.consumed_kind <= KIND_TEMPERATURE;
        res.next_start <= NS_PRESSURE;
      end
      ST_P_SENS: begin
        off <= $signed({4'b0, cfg.pressure_offset, {OFF_BASE_SHIFT{1'b0}}}) +
               OFF_W'(prod >>> OFF_COEFF_SHIFT);
      end
      ST_P_SPLIT: begin
        sens <= $signed({4'b0, cfg.pressure_sensitivity, {SENS_BASE_SHIFT{1'b0}}}) +
                SENS_W'(prod >>> SENS_COEFF_SHIFT);
      end
      ST_P_HI: begin
        acc <= ACC_W'(prod);
      end
      ST_P_ACC: begin
        acc <= acc + (ACC_W'(prod) <<< SENS_LO_W);
      end
      ST_P_FIN: begin
        res.pressure_fixed <= p_val;
        res.temperature_fixed <= held_temperature;
        res.consumed <= 1'b1;
        res.consumed_kind <= KIND_PRESSURE;
        res.next_start <= phase_wrap ? NS_TEMPERATURE : NS_PRESSURE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data <= res;
    end
  end

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !limited) |=> (state == ST_T_MUL || state == ST_P_OFF))
    else $error("accepted poll did not start a conversion");

  a_consumed_has_next: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.consumed == (out_data.next_start != NS_NONE)))
    else $error("next_start does not agree with consumed");

  a_temp_then_pressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.consumed && out_data.consumed_kind == KIND_TEMPERATURE)
      |-> out_data.next_start == NS_PRESSURE)
    else $error("temperature read not followed by pressure start");

  a_wrap_clears_phase: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res.next_start == NS_TEMPERATURE) |-> read_phase == '0)
    else $error("read cycle ended with nonzero phase");

  a_limited_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free && !res.consumed)
      |=> ($stable(held_pressure) && $stable(held_temperature)))
    else $error("held readings changed on a rate-limited poll");

endmodule

// ===== test/baro_compensation_sequencer_unit_tb.sv =====
// Self-checking testbench of the barometric compensation sequencer, with an inline predictor.
`timescale 1ns / 100ps

module baro_compensation_sequencer_unit_tb;
  import bcs_pkg::*;

  localparam longint CYCLE_LIMIT = 1000000;
  localparam int REF_TEMP_SHIFT = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 100;
  localparam longint T_LO = -(longint'(1) << (TEMP_W - 1));
  localparam longint T_HI = (longint'(1) << (TEMP_W - 1)) - 1;
  localparam longint P_LO = -(longint'(1) << (PRES_W - 1));
  localparam longint P_HI = (longint'(1) << (PRES_W - 1)) - 1;

  localparam cfg_t TYPICAL_CAL = '{
    pressure_sensitivity: 16'd40127, pressure_offset: 16'd36924,
    sens_temp_coeff: 16'd23317, offset_temp_coeff: 16'd23282,
    reference_temp: 16'd33464, temp_sensitivity: 16'd28312,
    reads_per_cycle: 4'd2, min_poll_ticks: 8'd10};
  localparam cfg_t FULL_SCALE_CAL = '{
    pressure_sensitivity: 16'hFFFF, pressure_offset: 16'hFFFF,
    sens_temp_coeff: 16'hFFFF, offset_temp_coeff: 16'hFFFF,
    reference_temp: 16'hFFFF, temp_sensitivity: 16'hFFFF,
    reads_per_cycle: 4'd15, min_poll_ticks: 8'd255};
  localparam cfg_t EMPTY_CAL = '{
    pressure_sensitivity: 16'h0, pressure_offset: 16'h0,
    sens_temp_coeff: 16'h0, offset_temp_coeff: 16'h0,
    reference_temp: 16'h0, temp_sensitivity: 16'h0,
    reads_per_cycle: 4'd2, min_poll_ticks: 8'd0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COEFF_W-1:0] cfg_data = '0;

  in_t poll_queue[$];
  out_t expected_readings[$];
  int polls_queued = 0;
  int polls_accepted = 0;
  int readings_checked = 0;
  int mismatches = 0;
  longint cycle_count = 0;
  logic [TICK_W-1:0] tick_clock = '0;
  bit in_fire = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  cfg_t settings = '{
    pressure_sensitivity: '0, pressure_offset: '0, sens_temp_coeff: '0,
    offset_temp_coeff: '0, reference_temp: '0, temp_sensitivity: '0,
    reads_per_cycle: READS_RESET, min_poll_ticks: POLL_RESET};
  logic [PHASE_W-1:0] cycle_phase = '0;
  logic [TICK_W-1:0] last_tick = '0;
  longint delta_t = 0;
  longint pres_held = 0;
  longint temp_held = 0;

  baro_compensation_sequencer_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic out_t compensate_poll(in_t p);
    out_t r;
    longint raw;
    longint off;
    longint sens;
    logic [TICK_W-1:0] since;
    r = '0;
    r.consumed_kind = KIND_TEMPERATURE;
    r.next_start = NS_NONE;
    raw = longint'(p.raw_value);
    since = p.tick_now - last_tick;
    if (since >= settings.min_poll_ticks) begin
      last_tick = p.tick_now;
      r.consumed = 1'b1;
      if (cycle_phase == 0) begin
        cycle_phase = PHASE_W'(1);
        delta_t = (raw == 0) ? 0 :
            raw - (longint'(settings.reference_temp) << REF_TEMP_SHIFT);
        temp_held = (delta_t == 0) ? 0 :
            sat(TEMP_BASE + ((delta_t * longint'(settings.temp_sensitivity)) >>> TEMP_SHIFT),
                T_LO, T_HI);
        r.consumed_kind = KIND_TEMPERATURE;
        r.next_start = NS_PRESSURE;
      end else begin
        cycle_phase = cycle_phase + 1'b1;
        off = (longint'(settings.pressure_offset) << OFF_BASE_SHIFT)
            + ((longint'(settings.offset_temp_coeff) * delta_t) >>> OFF_COEFF_SHIFT);
        sens = (longint'(settings.pressure_sensitivity) << SENS_BASE_SHIFT)
            + ((longint'(settings.sens_temp_coeff) * delta_t) >>> SENS_COEFF_SHIFT);
        pres_held = (raw == 0 || delta_t == 0) ? 0 :
            sat((((raw * sens) >>> RAW_SENS_SHIFT) - off) >>> PRES_SHIFT, P_LO, P_HI);
        r.consumed_kind = KIND_PRESSURE;
        if (cycle_phase >= settings.reads_per_cycle || cycle_phase == 0) begin
          cycle_phase = '0;
          r.next_start = NS_TEMPERATURE;
        end else begin
          r.next_start = NS_PRESSURE;
        end
      end
    end
    r.pressure_fixed = PRES_W'(pres_held);
    r.temperature_fixed = TEMP_W'(temp_held);
    return r;
  endfunction

  function automatic int pick_gap(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 13) return 0;
    if (roll < 17) return $urandom_range(1, 2);
    if (roll < 19) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [TICK_W-1:0] pick_advance();
    int m;
    m = int'(settings.min_poll_ticks);
    case ($urandom_range(0, 19))
      0, 1: return (m == 0) ? 0 : $urandom_range(0, m - 1);
      2: return m;
      3: return $urandom;
      default: return m + $urandom_range(0, 20);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    int c;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return RAW_W'($urandom);
      4, 5, 6: begin
        c = (int'(settings.reference_temp) << REF_TEMP_SHIFT)
            + int'($urandom_range(0, 8191)) - 4096;
        if (c < 0) c = 0;
        if (c > 24'hFFFFFF) c = 24'hFFFFFF;
        return RAW_W'(c);
      end
      default: return RAW_W'($urandom_range(6000000, 10000000));
    endcase
  endfunction

  task automatic queue_poll(logic [TICK_W-1:0] advance, logic [RAW_W-1:0] raw);
    tick_clock = tick_clock + advance;
    poll_queue.push_back('{tick_now: tick_clock, raw_value: raw});
    polls_queued++;
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      report_mismatch($sformatf("reading %0d %s got %0d expected %0d",
                                readings_checked, name, got, want));
  endtask

  // call at a falling edge with the block idle
  task automatic load_settings(cfg_t c);
    cfg_reg_e r;
    r = r.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      case (r)
        REG_PRESSURE_SENSITIVITY: cfg_data <= c.pressure_sensitivity;
        REG_PRESSURE_OFFSET:      cfg_data <= c.pressure_offset;
        REG_SENS_TEMP_COEFF:      cfg_data <= c.sens_temp_coeff;
        REG_OFFSET_TEMP_COEFF:    cfg_data <= c.offset_temp_coeff;
        REG_REFERENCE_TEMP:       cfg_data <= c.reference_temp;
        REG_TEMP_SENSITIVITY:     cfg_data <= c.temp_sensitivity;
        REG_READS_PER_CYCLE:      cfg_data <= COEFF_W'(c.reads_per_cycle);
        REG_MIN_POLL_TICKS:       cfg_data <= COEFF_W'(c.min_poll_ticks);
        default:                  cfg_data <= '0;
      endcase
      do @(posedge clk); while (cfg_ready !== 1'b1);
      @(negedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_valid <= 1'b0;
    settings = c;
  endtask

  task automatic wait_idle();
    while (polls_accepted != polls_queued || readings_checked != polls_accepted)
      @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // accept and predict
  always @(posedge clk) begin
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      expected_readings.push_back(compensate_poll(in_data));
      polls_accepted++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (poll_queue.size() > 0) begin
        in_data <= poll_queue.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_gap(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(recv_calm);
    end
  end

  out_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, pressure %0d",
                                  out_data.pressure_fixed));
      end else begin
        want = expected_readings.pop_front();
        check_field("pressure_fixed", out_data.pressure_fixed, want.pressure_fixed);
        check_field("temperature_fixed", out_data.temperature_fixed,
                    want.temperature_fixed);
        check_field("consumed", out_data.consumed, want.consumed);
        check_field("consumed_kind", out_data.consumed_kind, want.consumed_kind);
        check_field("next_start", out_data.next_start, want.next_start);
        readings_checked++;
      end
    end
  end

  initial begin
    cfg_t plan;
    logic [127:0] noise;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings
    queue_poll(5, 24'h123456);
    queue_poll(5, 24'hABCDEF);
    queue_poll(10, 24'hFFFFFF);
    wait_idle();

    load_settings(TYPICAL_CAL);
    queue_poll(9, 24'd8000000);
    queue_poll(1, 24'd8000000);
    queue_poll(10, {TYPICAL_CAL.reference_temp, 8'h00});
    queue_poll(10, 24'd9000000);
    queue_poll(10, 24'd0);
    queue_poll(10, 24'hFFFFFF);
    queue_poll(10, 24'd8077636);
    queue_poll(10, 24'd0);
    queue_poll(10, 24'hFFFFFF);
    queue_poll(10, 24'd1);
    queue_poll(10, 24'd1);
    queue_poll(10, 24'hFFFFFF);
    wait_idle();

    load_settings(FULL_SCALE_CAL);
    tick_clock = 32'hFFFF_FF00;
    queue_poll(0, 24'd1);
    queue_poll(254, 24'hFFFFFF);
    queue_poll(1, 24'hFFFFFF);
    queue_poll(255, 24'd8000000);
    wait_idle();

    load_settings(EMPTY_CAL);
    queue_poll(0, 24'd5);
    queue_poll(0, 24'd0);
    queue_poll(0, 24'd7);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: plan = TYPICAL_CAL;
        1: begin
          noise = {$urandom, $urandom, $urandom, $urandom};
          plan = noise[$bits(cfg_t)-1:0];
        end
        2: plan = FULL_SCALE_CAL;
        default: plan = EMPTY_CAL;
      endcase
      if (ph == 0) plan = TYPICAL_CAL;
      plan.reads_per_cycle = PHASE_W'($urandom_range(2, 15));
      case ($urandom_range(0, 3))
        0: plan.min_poll_ticks = '0;
        1: plan.min_poll_ticks = 8'd255;
        default: plan.min_poll_ticks = POLL_W'($urandom_range(1, 40));
      endcase
      load_settings(plan);
      send_calm = (ph == 2 || ph == 5);
      recv_calm = (ph == 5);
      if (ph == 2) begin
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
      end
      if ($urandom_range(0, 1)) tick_clock = $urandom;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_poll(pick_advance(), pick_raw());
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bcs_pkg.sv
rtl/bcs_cfg_regs.sv
rtl/bcs_mul.sv
rtl/baro_compensation_sequencer_unit.sv
test/baro_compensation_sequencer_unit_tb.sv
